FILE: rtl/core/garf_pkg.sv
`timescale 1ns / 1ps

package garf_pkg;

    localparam int NUM_GATES  = 8;
    localparam int NUM_RANGES = 16;

    localparam int GATE_W   = (NUM_GATES > 1) ? $clog2(NUM_GATES) : 1;
    localparam int RANGE_W  = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1;
    localparam int PORT_W   = 16;
    localparam int ADDR_W   = 32;
    localparam int PREFIX_W = 6;

    localparam logic [GATE_W-1:0]   GATE_LAST  = GATE_W'(NUM_GATES - 1);
    localparam logic [RANGE_W-1:0]  RANGE_LAST = RANGE_W'(NUM_RANGES - 1);
    localparam logic [PREFIX_W-1:0] MAX_PREFIX = PREFIX_W'(ADDR_W);

    typedef enum logic [1:0] {
        ACT_DEFINE = 2'd0,
        ACT_ADD    = 2'd1,
        ACT_CHECK  = 2'd2,
        ACT_UNUSED = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        VERD_NO_GATE = 2'd0,
        VERD_ALLOWED = 2'd1,
        VERD_REFUSED = 2'd2,
        VERD_NONE    = 2'd3
    } verdict_t;

    typedef enum logic [1:0] {
        ERR_OK      = 2'd0,
        ERR_FULL    = 2'd1,
        ERR_PREFIX  = 2'd2,
        ERR_NO_GATE = 2'd3
    } err_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GATE,
        ST_RANGE,
        ST_DONE
    } garf_state_t;

    typedef struct packed {
        action_t               action;
        logic [PORT_W-1:0]     gate_port;
        logic [ADDR_W-1:0]     ip_address;
        logic [PREFIX_W-1:0]   prefix_bits;
    } garf_req_t;

    typedef struct packed {
        verdict_t verdict;
        err_t     error_code;
    } garf_res_t;

    // Netmask for a prefix length of 0 to 32; zero length gives an empty mask.
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PREFIX_W-1:0] bits);
        logic [ADDR_W-1:0] ones;
        ones = '1;
        if (bits == '0)
        begin
            return '0;
        end
        return ones << (MAX_PREFIX - bits);
    endfunction

endpackage

FILE: rtl/core/garf_engine.sv
`timescale 1ns / 1ps

module garf_engine
    import garf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  garf_req_t req,
    output logic      idle,
    output logic      done,
    output garf_res_t res,
    input  logic      take
);

    garf_state_t         state_reg, state_next;
    garf_req_t           req_reg, req_next;
    logic [ADDR_W-1:0]   mask_reg, mask_next;
    logic [GATE_W-1:0]   gidx_reg, gidx_next;
    logic                found_reg, found_next;
    logic [GATE_W-1:0]   fgate_reg, fgate_next;
    logic                free_reg, free_next;
    logic [GATE_W-1:0]   free_gate_reg, free_gate_next;
    logic [RANGE_W-1:0]  ridx_reg, ridx_next;
    logic                any_reg, any_next;
    logic                hit_reg, hit_next;
    logic                slot_reg, slot_next;
    logic [RANGE_W-1:0]  slot_idx_reg, slot_idx_next;
    garf_res_t           res_reg, res_next;

    // Tables
    logic                gate_valid_reg [NUM_GATES];
    logic [PORT_W-1:0]   gate_key_reg [NUM_GATES];
    logic                range_valid_reg [NUM_RANGES];
    logic [GATE_W-1:0]   range_owner_reg [NUM_RANGES];
    logic [ADDR_W-1:0]   range_low_reg [NUM_RANGES];
    logic [ADDR_W-1:0]   range_high_reg [NUM_RANGES];

    logic                gate_wr_en;
    logic [GATE_W-1:0]   gate_wr_idx;
    logic                range_wr_en;
    logic [RANGE_W-1:0]  range_wr_idx;
    logic                range_clr_en;

    logic                gate_match;
    logic                range_owned;
    logic                range_hit;

    assign gate_match  = gate_valid_reg[gidx_reg] && (gate_key_reg[gidx_reg] == req_reg.gate_port);
    assign range_owned = range_valid_reg[ridx_reg] && (range_owner_reg[ridx_reg] == fgate_reg);
    assign range_hit   = (req_reg.ip_address >= range_low_reg[ridx_reg]) &&
                         (req_reg.ip_address <= range_high_reg[ridx_reg]);

    assign idle = (state_reg == ST_IDLE);
    assign done = (state_reg == ST_DONE);
    assign res  = res_reg;

    always_comb
    begin
        logic                found_v;
        logic [GATE_W-1:0]   fgate_v;
        logic                free_v;
        logic [GATE_W-1:0]   free_gate_v;
        logic                any_v;
        logic                hit_v;
        logic                slot_v;
        logic [RANGE_W-1:0]  slot_idx_v;

        state_next     = state_reg;
        req_next       = req_reg;
        mask_next      = mask_reg;
        gidx_next      = gidx_reg;
        found_next     = found_reg;
        fgate_next     = fgate_reg;
        free_next      = free_reg;
        free_gate_next = free_gate_reg;
        ridx_next      = ridx_reg;
        any_next       = any_reg;
        hit_next       = hit_reg;
        slot_next      = slot_reg;
        slot_idx_next  = slot_idx_reg;
        res_next       = res_reg;
        gate_wr_en     = 1'b0;
        gate_wr_idx    = free_gate_reg;
        range_wr_en    = 1'b0;
        range_wr_idx   = slot_idx_reg;
        range_clr_en   = 1'b0;

        found_v     = found_reg;
        fgate_v     = fgate_reg;
        free_v      = free_reg;
        free_gate_v = free_gate_reg;
        any_v       = any_reg;
        hit_v       = hit_reg;
        slot_v      = slot_reg;
        slot_idx_v  = slot_idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next   = req;
                    mask_next  = prefix_mask(req.prefix_bits);
                    gidx_next  = '0;
                    ridx_next  = '0;
                    found_next = 1'b0;
                    free_next  = 1'b0;
                    any_next   = 1'b0;
                    hit_next   = 1'b0;
                    slot_next  = 1'b0;
                    case (req.action)
                        ACT_DEFINE, ACT_CHECK:
                        begin
                            state_next = ST_GATE;
                        end
                        ACT_ADD:
                        begin
                            if (req.prefix_bits > MAX_PREFIX)
                            begin
                                res_next   = '{verdict: VERD_NONE, error_code: ERR_PREFIX};
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_GATE;
                            end
                        end
                        default:
                        begin
                            res_next   = '{verdict: VERD_NONE, error_code: ERR_OK};
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_GATE:
            begin
                // First matching gate and lowest free slot
                if (gate_match && !found_v)
                begin
                    found_v = 1'b1;
                    fgate_v = gidx_reg;
                end
                if (!gate_valid_reg[gidx_reg] && !free_v)
                begin
                    free_v      = 1'b1;
                    free_gate_v = gidx_reg;
                end
                found_next     = found_v;
                fgate_next     = fgate_v;
                free_next      = free_v;
                free_gate_next = free_gate_v;

                if (gidx_reg == GATE_LAST)
                begin
                    case (req_reg.action)
                        ACT_DEFINE:
                        begin
                            if (found_v)
                            begin
                                state_next = ST_RANGE;
                            end
                            else if (free_v)
                            begin
                                gate_wr_en  = 1'b1;
                                gate_wr_idx = free_gate_v;
                                fgate_next  = free_gate_v;
                                state_next  = ST_RANGE;
                            end
                            else
                            begin
                                res_next   = '{verdict: VERD_NONE, error_code: ERR_FULL};
                                state_next = ST_DONE;
                            end
                        end
                        ACT_ADD:
                        begin
                            if (found_v)
                            begin
                                state_next = ST_RANGE;
                            end
                            else
                            begin
                                res_next   = '{verdict: VERD_NONE, error_code: ERR_NO_GATE};
                                state_next = ST_DONE;
                            end
                        end
                        ACT_CHECK:
                        begin
                            if (found_v)
                            begin
                                state_next = ST_RANGE;
                            end
                            else
                            begin
                                res_next   = '{verdict: VERD_NO_GATE, error_code: ERR_OK};
                                state_next = ST_DONE;
                            end
                        end
                        default:
                        begin
                            res_next   = '{verdict: VERD_NONE, error_code: ERR_OK};
                            state_next = ST_DONE;
                        end
                    endcase
                end
                else
                begin
                    gidx_next = gidx_reg + GATE_W'(1);
                end
            end

            ST_RANGE:
            begin
                case (req_reg.action)
                    ACT_DEFINE:
                    begin
                        range_clr_en = range_owned;
                    end
                    ACT_ADD:
                    begin
                        if (!range_valid_reg[ridx_reg] && !slot_v)
                        begin
                            slot_v     = 1'b1;
                            slot_idx_v = ridx_reg;
                        end
                    end
                    ACT_CHECK:
                    begin
                        if (range_owned)
                        begin
                            any_v = 1'b1;
                            hit_v = hit_v | range_hit;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                any_next      = any_v;
                hit_next      = hit_v;
                slot_next     = slot_v;
                slot_idx_next = slot_idx_v;

                if (ridx_reg == RANGE_LAST)
                begin
                    state_next = ST_DONE;
                    case (req_reg.action)
                        ACT_ADD:
                        begin
                            if (slot_v)
                            begin
                                range_wr_en  = 1'b1;
                                range_wr_idx = slot_idx_v;
                                res_next     = '{verdict: VERD_NONE, error_code: ERR_OK};
                            end
                            else
                            begin
                                res_next = '{verdict: VERD_NONE, error_code: ERR_FULL};
                            end
                        end
                        ACT_CHECK:
                        begin
                            if (any_v && !hit_v)
                            begin
                                res_next = '{verdict: VERD_REFUSED, error_code: ERR_OK};
                            end
                            else
                            begin
                                res_next = '{verdict: VERD_ALLOWED, error_code: ERR_OK};
                            end
                        end
                        default:
                        begin
                            res_next = '{verdict: VERD_NONE, error_code: ERR_OK};
                        end
                    endcase
                end
                else
                begin
                    ridx_next = ridx_reg + RANGE_W'(1);
                end
            end

            ST_DONE:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        mask_reg      <= mask_next;
        gidx_reg      <= gidx_next;
        found_reg     <= found_next;
        fgate_reg     <= fgate_next;
        free_reg      <= free_next;
        free_gate_reg <= free_gate_next;
        ridx_reg      <= ridx_next;
        any_reg       <= any_next;
        hit_reg       <= hit_next;
        slot_reg      <= slot_next;
        slot_idx_reg  <= slot_idx_next;
        res_reg       <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_GATES; i++)
            begin
                gate_valid_reg[i] <= 1'b0;
            end
            for (int i = 0; i < NUM_RANGES; i++)
            begin
                range_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (gate_wr_en)
            begin
                gate_valid_reg[gate_wr_idx] <= 1'b1;
            end
            if (range_clr_en)
            begin
                range_valid_reg[ridx_reg] <= 1'b0;
            end
            if (range_wr_en)
            begin
                range_valid_reg[range_wr_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (gate_wr_en)
        begin
            gate_key_reg[gate_wr_idx] <= req_reg.gate_port;
        end
        if (range_wr_en)
        begin
            range_owner_reg[range_wr_idx] <= fgate_reg;
            range_low_reg[range_wr_idx]   <= req_reg.ip_address & mask_reg;
            range_high_reg[range_wr_idx]  <= (req_reg.ip_address & mask_reg) | ~mask_reg;
        end
    end

endmodule

FILE: rtl/core/gate_address_range_filter.sv
`timescale 1ns / 1ps

// Channel   Direction  tdata (low bit up)                          tuser
// s_axis    in         gate_port[15:0] ip_address[47:16]           action[1:0]
//                      prefix_bits[53:48], zero pad [55:54]
// m_axis    out        verdict[1:0] error_code[3:2], zero pad       -
//
// Each item walks the gate table one entry a cycle, then, once the gate is known, the
// range table one entry a cycle. A bad prefix or the unused action skips both walks;
// a missing gate or a full gate table skips the range walk. The engine takes one item
// at a time. Reset clears the valid bits of both tables at once; keys and ranges hold
// garbage until written. The result register frees the engine while a result waits on
// m_axis_tready.

module gate_address_range_filter
    import garf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // gate_port, ip_address, prefix_bits, pad
    input  logic [1:0]  s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // verdict, error_code, pad
);

    garf_req_t  eng_req;
    garf_res_t  eng_res;
    logic       eng_idle;
    logic       eng_done;
    logic       eng_start;
    logic       eng_take;

    logic       m_valid_reg, m_valid_next;
    garf_res_t  m_res_reg, m_res_next;

    // Unpack the incoming item
    assign eng_req.action      = action_t'(s_axis_tuser);
    assign eng_req.gate_port   = s_axis_tdata[15:0];
    assign eng_req.ip_address  = s_axis_tdata[47:16];
    assign eng_req.prefix_bits = s_axis_tdata[53:48];

    assign s_axis_tready = eng_idle;
    assign eng_start     = s_axis_tvalid && eng_idle;

    // Move the finished result into the output register once it is free
    assign eng_take = eng_done && (!m_valid_reg || m_axis_tready);

    garf_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .start (eng_start),
        .req   (eng_req),
        .idle  (eng_idle),
        .done  (eng_done),
        .res   (eng_res),
        .take  (eng_take)
    );

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (eng_take)
        begin
            m_valid_next = 1'b1;
            m_res_next   = eng_res;
        end
        else if (m_axis_tready)
        begin
            // Drop the result once taken
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_res_reg <= m_res_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'b0000, m_res_reg.error_code, m_res_reg.verdict};

endmodule

FILE: test/gate_address_range_filter_tb.sv
`timescale 1ns / 1ps

module gate_address_range_filter_tb;
    import garf_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 7;
    localparam int PHASE_ITEMS    = 456;   // random items in each of four phases
    localparam int HOLD_OFF_LEN   = 200;   // receiver hold-off in cycles
    localparam int SETTLE_CYCLES  = 40;    // longer than a full gate and range walk

    // Golden view of the gate and range tables, plus the verdicts still owed.
    class gate_filter_scoreboard;
        bit                gate_used [NUM_GATES];
        logic [PORT_W-1:0] gate_port_of [NUM_GATES];
        bit                range_used [NUM_RANGES];
        int                range_gate [NUM_RANGES];
        logic [ADDR_W-1:0] range_lo [NUM_RANGES];
        logic [ADDR_W-1:0] range_hi [NUM_RANGES];
        garf_res_t         pending_verdicts[$];

        function int find_gate(input logic [PORT_W-1:0] port);
            for (int g = 0; g < NUM_GATES; g++)
            begin
                if (gate_used[g] && gate_port_of[g] == port)
                begin
                    return g;
                end
            end
            return -1;
        endfunction

        // Work out the verdict of one accepted item and update the tables.
        function void note_item(input garf_req_t item);
            garf_res_t         res;
            int                g;
            int                slot;
            logic [ADDR_W-1:0] mask;
            bit                any_range;
            bit                hit;
            res.verdict    = VERD_NONE;
            res.error_code = ERR_OK;
            case (item.action)
                ACT_DEFINE:
                begin
                    g = find_gate(item.gate_port);
                    if (g < 0)
                    begin
                        for (int r = 0; r < NUM_GATES; r++)
                        begin
                            if (g < 0 && !gate_used[r])
                            begin
                                g = r;
                            end
                        end
                        if (g >= 0)
                        begin
                            gate_used[g]    = 1'b1;
                            gate_port_of[g] = item.gate_port;
                        end
                    end
                    if (g < 0)
                    begin
                        res.error_code = ERR_FULL;
                    end
                    else
                    begin
                        for (int r = 0; r < NUM_RANGES; r++)
                        begin
                            if (range_used[r] && range_gate[r] == g)
                            begin
                                range_used[r] = 1'b0;
                            end
                        end
                    end
                end
                ACT_ADD:
                begin
                    g = find_gate(item.gate_port);
                    slot = -1;
                    for (int r = 0; r < NUM_RANGES; r++)
                    begin
                        if (slot < 0 && !range_used[r])
                        begin
                            slot = r;
                        end
                    end
                    // prefix is judged before the gate lookup
                    if (item.prefix_bits > MAX_PREFIX)
                    begin
                        res.error_code = ERR_PREFIX;
                    end
                    else if (g < 0)
                    begin
                        res.error_code = ERR_NO_GATE;
                    end
                    else if (slot < 0)
                    begin
                        res.error_code = ERR_FULL;
                    end
                    else
                    begin
                        // a shift by the full width leaves an empty mask
                        mask = '1;
                        mask = mask << (ADDR_W - int'(item.prefix_bits));
                        range_used[slot] = 1'b1;
                        range_gate[slot] = g;
                        range_lo[slot]   = item.ip_address & mask;
                        range_hi[slot]   = (item.ip_address & mask) | ~mask;
                    end
                end
                ACT_CHECK:
                begin
                    g = find_gate(item.gate_port);
                    if (g < 0)
                    begin
                        res.verdict = VERD_NO_GATE;
                    end
                    else
                    begin
                        any_range = 1'b0;
                        hit       = 1'b0;
                        for (int r = 0; r < NUM_RANGES; r++)
                        begin
                            if (range_used[r] && range_gate[r] == g)
                            begin
                                any_range = 1'b1;
                                if (item.ip_address >= range_lo[r] &&
                                    item.ip_address <= range_hi[r])
                                begin
                                    hit = 1'b1;
                                end
                            end
                        end
                        res.verdict = (!any_range || hit) ? VERD_ALLOWED : VERD_REFUSED;
                    end
                end
                default:
                begin
                    res.verdict = VERD_NONE;
                end
            endcase
            pending_verdicts.push_back(res);
        endfunction

        function bit check_result(input logic [7:0] word, output string why);
            garf_res_t want;
            why = "";
            if (pending_verdicts.size() == 0)
            begin
                why = $sformatf("result %h with nothing pending", word);
                return 1'b0;
            end
            want = pending_verdicts.pop_front();
            if (word[1:0] !== want.verdict)
            begin
                why = {why, $sformatf(" verdict %0d want %0d", word[1:0], want.verdict)};
            end
            if (word[3:2] !== want.error_code)
            begin
                why = {why, $sformatf(" error %0d want %0d", word[3:2], want.error_code)};
            end
            if (word[7:4] !== 4'h0)
            begin
                why = {why, $sformatf(" pad %h not zero", word[7:4])};
            end
            return why == "";
        endfunction

        function int outstanding();
            return pending_verdicts.size();
        endfunction

        // Port of a random live gate, or any port while none is defined.
        function logic [PORT_W-1:0] known_port();
            int live[$];
            for (int g = 0; g < NUM_GATES; g++)
            begin
                if (gate_used[g])
                begin
                    live.push_back(g);
                end
            end
            if (live.size() == 0)
            begin
                return PORT_W'($urandom);
            end
            return gate_port_of[live[$urandom_range(live.size() - 1)]];
        endfunction

        // Address on or just beside an edge of one of this port's ranges, or any address if none.
        function logic [ADDR_W-1:0] edge_address(input logic [PORT_W-1:0] port);
            int owned[$];
            int g;
            int r;
            g = find_gate(port);
            for (int i = 0; i < NUM_RANGES; i++)
            begin
                if (g >= 0 && range_used[i] && range_gate[i] == g)
                begin
                    owned.push_back(i);
                end
            end
            if (owned.size() == 0)
            begin
                return $urandom;
            end
            r = owned[$urandom_range(owned.size() - 1)];
            case ($urandom_range(3))
                0:       return range_lo[r];
                1:       return range_hi[r];
                2:       return range_lo[r] - 1'b1;
                default: return range_hi[r] + 1'b1;
            endcase
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;   // gate_port, ip_address, prefix_bits, pad
    logic [1:0]  s_axis_tuser;   // action
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // verdict, error_code, pad

    gate_filter_scoreboard ledger;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int hold_off_left      = 0;
    int mismatch_count     = 0;

    gate_address_range_filter uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at %0t ns:%s", $time, what);
    endtask

    // Offer one item from a falling edge, idling first at random, and hold it
    // until the block takes it. Return on the next falling edge.
    task automatic drive_item(input garf_req_t item);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, item.prefix_bits, item.ip_address, item.gate_port};
        s_axis_tuser  <= item.action;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        ledger.note_item(item);
        @(negedge clk);
    endtask

    task automatic send_fields(input action_t act, input logic [PORT_W-1:0] port,
                               input logic [ADDR_W-1:0] addr,
                               input logic [PREFIX_W-1:0] bits);
        garf_req_t item;
        item.action      = act;
        item.gate_port   = port;
        item.ip_address  = addr;
        item.prefix_bits = bits;
        drive_item(item);
    endtask

    // Random item: mostly live ports so that adds and checks reach the range
    // walk, edge addresses for many checks, and a share of bad prefixes.
    task automatic send_random_item();
        garf_req_t item;
        int        pick;
        pick = $urandom_range(99);
        if (pick < 14)
        begin
            item.action = ACT_DEFINE;
        end
        else if (pick < 50)
        begin
            item.action = ACT_ADD;
        end
        else if (pick < 96)
        begin
            item.action = ACT_CHECK;
        end
        else
        begin
            item.action = ACT_UNUSED;
        end
        item.gate_port  = ($urandom_range(99) < 80) ? ledger.known_port() : PORT_W'($urandom);
        item.ip_address = $urandom;
        pick = $urandom_range(99);
        if (pick < 3)
        begin
            item.prefix_bits = '0;
        end
        else if (pick < 92)
        begin
            item.prefix_bits = PREFIX_W'($urandom_range(1, 32));
        end
        else
        begin
            item.prefix_bits = PREFIX_W'($urandom_range(33, 63));
        end
        if (item.action == ACT_CHECK && $urandom_range(99) < 60)
        begin
            item.ip_address = ledger.edge_address(item.gate_port);
        end
        drive_item(item);
    endtask

    // Receiver: stall at random, or hold off for a counted stretch on request.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_off_left = hold_off_left - 1;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // Compare each accepted result with the oldest verdict owed.
    always @(posedge clk)
    begin
        string why;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (!ledger.check_result(m_axis_tdata, why))
            begin
                report_mismatch(why);
            end
        end
    end

    initial
    begin
        logic [PORT_W-1:0] wide_port;
        ledger        = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty tables, lookup failures and the unused code.
        send_fields(ACT_CHECK, 16'h0000, 32'h0000_0000, 6'd0);
        send_fields(ACT_ADD, 16'h0000, 32'hC0A8_0100, 6'd8);
        send_fields(ACT_ADD, 16'h0000, 32'hC0A8_0100, 6'd33);
        send_fields(ACT_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 6'd63);
        // A gate with no ranges lets everyone in.
        send_fields(ACT_DEFINE, 16'h0000, 32'h0000_0000, 6'd0);
        send_fields(ACT_CHECK, 16'h0000, 32'h0000_0000, 6'd0);
        // Base gets masked down to the prefix; probe both edges.
        send_fields(ACT_ADD, 16'h0000, 32'hC0A8_01FF, 6'd24);
        send_fields(ACT_CHECK, 16'h0000, 32'hC0A8_0100, 6'd0);
        send_fields(ACT_CHECK, 16'h0000, 32'hC0A8_00FF, 6'd0);
        send_fields(ACT_CHECK, 16'h0000, 32'hC0A8_0200, 6'd0);
        // Host range at the top of the address space, then a bad prefix.
        send_fields(ACT_DEFINE, 16'hFFFF, 32'h0000_0000, 6'd0);
        send_fields(ACT_ADD, 16'hFFFF, 32'hFFFF_FFFF, 6'd32);
        send_fields(ACT_CHECK, 16'hFFFF, 32'hFFFF_FFFF, 6'd0);
        send_fields(ACT_CHECK, 16'hFFFF, 32'hFFFF_FFFE, 6'd0);
        send_fields(ACT_ADD, 16'hFFFF, 32'h0000_0000, 6'd63);
        // Zero prefix covers everything.
        send_fields(ACT_ADD, 16'hFFFF, 32'h1234_5678, 6'd0);
        send_fields(ACT_CHECK, 16'hFFFF, 32'h0000_0000, 6'd0);
        // Redefining a gate drops its ranges.
        send_fields(ACT_DEFINE, 16'h0000, 32'h0000_0000, 6'd0);
        send_fields(ACT_CHECK, 16'h0000, 32'h0000_0000, 6'd0);
        // Fill the gate table and then overflow it.
        repeat (7)
        begin
            wide_port = PORT_W'($urandom_range(1, 65534));
            send_fields(ACT_DEFINE, wide_port, $urandom, 6'd0);
        end

        // Random phases: free running with a long hold-off first, then sender
        // gaps, receiver stalls, and both together.
        hold_off_left = HOLD_OFF_LEN;
        repeat (PHASE_ITEMS) send_random_item();
        sender_idle_pct    = 69;
        receiver_stall_pct = 0;
        repeat (PHASE_ITEMS) send_random_item();
        sender_idle_pct    = 0;
        receiver_stall_pct = 69;
        repeat (PHASE_ITEMS) send_random_item();
        sender_idle_pct    = 26;
        receiver_stall_pct = 26;
        repeat (PHASE_ITEMS) send_random_item();
        s_axis_tvalid <= 1'b0;

        // Drain, then give the block time to show any stray result.
        while (ledger.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial
    begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

FILE: gate_address_range_filter.f
rtl/core/garf_pkg.sv
rtl/core/garf_engine.sv
rtl/core/gate_address_range_filter.sv
test/gate_address_range_filter_tb.sv
